// ===== hw/rtl/descending_prime_finder_macros.svh =====
// Assertion macros for the prime search RTL.
`ifndef DESCENDING_PRIME_FINDER_MACROS_SVH
`define DESCENDING_PRIME_FINDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prime search check failed");

// Next-cycle implication, checked outside reset.
`define DPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prime search check failed");

`endif

// ===== hw/rtl/dpf_pkg.sv =====
`default_nettype none
package dpf_pkg;

  localparam int MAX_COUNT_DEF  = 16;
  localparam int VALUE_BITS_DEF = 32;

  typedef struct packed {
    logic [31:0] upper_limit;
    logic [4:0]  wanted_count;
  } request_t;

  typedef struct packed {
    logic [31:0] prime_value;
    logic [3:0]  prime_index;
    logic        last;
    logic        short_flag;
    logic        none_found;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_TEST,
    S_DIV,
    S_STEP,
    S_PRIME,
    S_FLUSH
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/descending_prime_finder.sv =====
// Each trial divisor d takes one S_TEST state, a pass of the bit-serial remainder unit in
// S_DIV that takes one dividend bit per cycle, and one S_STEP state; a candidate n tries
// divisors from 2 upward until one divides n or d*d exceeds n; candidates are scanned downward.
// One request at a time: each result is strobed for one cycle; the final one goes out via
// S_FLUSH and the strobe register, busy falls with it, and the next request is taken then.
// Reset is synchronous and clears only the control state; no clearing pass is needed.
`default_nettype none
`include "descending_prime_finder_macros.svh"
module descending_prime_finder #(
  parameter int MAX_COUNT  = dpf_pkg::MAX_COUNT_DEF,
  parameter int VALUE_BITS = dpf_pkg::VALUE_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire dpf_pkg::request_t request,
  output logic                   busy,
  output logic                   strobe,
  output dpf_pkg::result_t       result
);
  import dpf_pkg::*;

  localparam int VB = VALUE_BITS;
  localparam int DW = (VB + 1) / 2 + 1;   // divisor width, covers one step past sqrt
  localparam int SW = 2 * DW;             // square of the divisor
  localparam int CW = $clog2(MAX_COUNT + 1);
  localparam int BW = $clog2(VB);

  state_t state, state_next;

  logic [VB-1:0] cand;
  logic [DW-1:0] d;
  logic [SW-1:0] sq;
  logic [VB-1:0] sh;
  logic [DW-1:0] rem;
  logic [BW-1:0] bc;
  logic [CW-1:0] found;
  logic [CW-1:0] wanted;
  logic [VB-1:0] pend;
  logic [3:0]    pend_index;
  logic [3:0]    next_index;
  logic          pend_valid;
  logic          short_r;

  logic [CW-1:0] wanted_sat;
  logic          cand_done;
  logic          sq_over;
  logic          last_wanted;
  logic [DW:0]   trial;
  logic [DW-1:0] rem_next;
  logic          emit_pending;
  logic          emit_final;

  always_comb begin
    if (int'(request.wanted_count) > MAX_COUNT) begin
      wanted_sat = CW'(MAX_COUNT);
    end else begin
      wanted_sat = CW'(request.wanted_count);
    end
  end

  assign cand_done   = cand < VB'(2);
  assign sq_over     = sq > SW'(cand);
  assign last_wanted = (found + CW'(1)) == wanted;

  // One restoring step of the remainder: bring in the next dividend bit, subtract if it fits.
  assign trial = {rem, sh[VB-1]};
  always_comb begin
    if (trial >= {1'b0, d}) begin
      rem_next = DW'(trial - {1'b0, d});
    end else begin
      rem_next = trial[DW-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = (wanted_sat == '0) ? S_FLUSH : S_CHECK;
        end
      end
      S_CHECK: state_next = cand_done ? S_FLUSH : S_TEST;
      S_TEST:  state_next = sq_over ? S_PRIME : S_DIV;
      S_DIV: begin
        if (bc == '0) begin
          state_next = S_STEP;
        end
      end
      S_STEP:  state_next = (rem == '0) ? S_CHECK : S_TEST;
      S_PRIME: state_next = last_wanted ? S_FLUSH : S_CHECK;
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy         = 1'b1;
    emit_pending = 1'b0;
    emit_final   = 1'b0;
    case (state)
      S_IDLE:  busy = 1'b0;
      S_PRIME: emit_pending = pend_valid;
      S_FLUSH: emit_final = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit_pending || emit_final;
    end

    if (emit_pending) begin
      result.prime_value <= 32'(pend);
      result.prime_index <= pend_index;
      result.last        <= 1'b0;
      result.short_flag  <= 1'b0;
      result.none_found  <= 1'b0;
    end else if (emit_final) begin
      result.prime_value <= pend_valid ? 32'(pend) : 32'd0;
      result.prime_index <= pend_valid ? pend_index : 4'd0;
      result.last        <= 1'b1;
      result.short_flag  <= short_r;
      result.none_found  <= !pend_valid;
    end

    if (!rst) begin
      case (state)
        S_IDLE: begin
          if (start) begin
            cand       <= request.upper_limit[VB-1:0];
            wanted     <= wanted_sat;
            found      <= '0;
            next_index <= 4'd0;
            pend_valid <= 1'b0;
            short_r    <= 1'b0;
          end
        end
        S_CHECK: begin
          d  <= DW'(2);
          sq <= SW'(4);
          if (cand_done) begin
            short_r <= 1'b1;
          end
        end
        S_TEST: begin
          sh  <= cand;
          rem <= '0;
          bc  <= BW'(VB - 1);
        end
        S_DIV: begin
          sh  <= {sh[VB-2:0], 1'b0};
          rem <= rem_next;
          bc  <= bc - BW'(1);
        end
        S_STEP: begin
          if (rem == '0) begin
            cand <= cand - VB'(1);
          end else begin
            d  <= d + DW'(1);
            sq <= sq + SW'({d, 1'b1});
          end
        end
        S_PRIME: begin
          // The newest prime is held back so that it can still be marked as the last one.
          pend       <= cand;
          pend_index <= next_index;
          pend_valid <= 1'b1;
          next_index <= next_index + 4'd1;
          found      <= found + CW'(1);
          cand       <= cand - VB'(1);
        end
        default: begin
        end
      endcase
    end
  end

  `DPF_ASSERT_IMP(a_last_ends_request, strobe && result.last, !busy)
  `DPF_ASSERT_IMP(a_more_follow, strobe && !result.last, busy)
  `DPF_ASSERT_IMP(a_none_is_final, strobe && result.none_found, result.last && (result.prime_value == 32'd0))
  `DPF_ASSERT_NEXT(a_start_busy, start && !busy, busy)

endmodule
`default_nettype wire
